// ===== rtl/adrl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adrl_pkg
// Shared types and constants for the aileron droop rate limiter.
// ----------------------------------------------------------------------------
package adrl_pkg;

    // Default width of the clamped surface positions.
    localparam int unsigned POSITION_BITS_DEF = 16;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SURFACE_RATE    = 3'd0,
        REG_DROOP_RATE      = 3'd1,
        REG_ANTI_DROOP_RATE = 3'd2,
        REG_PITCH_REFERENCE = 3'd3,
        REG_FLAPS_THRESHOLD = 3'd4,
        REG_DROOP_DELAY_MS  = 3'd5,
        REG_DROOP_BIAS      = 3'd6,
        REG_ANTI_DROOP_BIAS = 3'd7
    } cfg_reg_t;

    // Register reset values
    localparam logic [15:0]        SURFACE_RATE_RST    = 16'd131;
    localparam logic [15:0]        DROOP_RATE_RST      = 16'd33;
    localparam logic [15:0]        ANTI_DROOP_RATE_RST = 16'd33;
    localparam logic signed [14:0] PITCH_REF_RST       = 15'sd0;
    localparam logic [14:0]        FLAPS_THRESH_RST    = 15'd0;
    localparam logic [15:0]        DROOP_DELAY_RST     = 16'd0;
    localparam logic signed [15:0] DROOP_BIAS_RST      = 16'sd0;
    localparam logic signed [15:0] ANTI_DROOP_BIAS_RST = 16'sd0;

    // Request layout on s_tdata, lowest bit first
    localparam int unsigned AP_LSB     = 0;
    localparam int unsigned SPL_LSB    = 1;
    localparam int unsigned NOW_LSB    = 2;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned PITCH_LSB  = 34;
    localparam int unsigned PITCH_W    = 15;
    localparam int unsigned HANDLE_LSB = 49;
    localparam int unsigned HANDLE_W   = 3;
    localparam int unsigned FLAPS_LSB  = 52;
    localparam int unsigned FLAPS_W    = 15;
    localparam int unsigned CMD_LSB    = 67;
    localparam int unsigned CMD_W      = 16;
    localparam int unsigned MS_LSB     = 83;
    localparam int unsigned MS_W       = 10;
    localparam int unsigned IN_USED_W  = 93;
    localparam int unsigned IN_TDATA_W = 96;

    // Result layout on m_tdata
    localparam int unsigned OUT_FIELD_W = 16;
    localparam int unsigned OUT_TDATA_W = 32;

    // Width of rate * frame_ms
    localparam int unsigned RATE_W = 16;
    localparam int unsigned STEP_W = RATE_W + MS_W;

endpackage : adrl_pkg
`default_nettype wire

// ===== rtl/aileron_droop_rate_limiter_unit.sv =====
`default_nettype none
// Pipeline: a request passes through the input register, then the
//          state/result register.
// Throughput: one request per cycle while the result is not stalled; the limiter
//          state is updated in the same cycle the request moves into the result register.
// Reset: aresetn (synchronous) clears all limiter state, loads register defaults
//        and empties both stages.
// ----------------------------------------------------------------------------
// aileron_droop_rate_limiter_unit
// Droop / anti-droop bias generation with four slew limiters feeding the left
// and right aileron positions.
// ----------------------------------------------------------------------------
module aileron_droop_rate_limiter_unit #(
    parameter int unsigned POSITION_BITS = adrl_pkg::POSITION_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration
    input  wire                                 cfg_we,
    input  wire [adrl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire [adrl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // request channel
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // autopilot_on, spoilers_deployed, now_ms, pitch_centideg, flaps_handle,
    // flaps_extension, aileron_command, frame_ms, zero padding
    input  wire [adrl_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result channel
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // left_position, right_position
    output logic [adrl_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned P      = POSITION_BITS;
    localparam int unsigned STEP_W = adrl_pkg::STEP_W;
    localparam int unsigned SL_W   = (P > 16) ? P : 16;
    localparam int unsigned DW     = (((SL_W + 1) > STEP_W) ? (SL_W + 1) : STEP_W) + 1;
    localparam int unsigned SUM_W  = 18;
    localparam int unsigned EXT_W  = (P > SUM_W) ? P : SUM_W;
    localparam logic signed [EXT_W-1:0] POS_HI = EXT_W'((64'sd1 <<< (P - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] POS_LO = -POS_HI - EXT_W'(1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        surface_rate_reg, droop_rate_reg, anti_droop_rate_reg;
    logic signed [14:0] pitch_ref_reg;
    logic [14:0]        flaps_thresh_reg;
    logic [15:0]        droop_delay_reg;
    logic signed [15:0] droop_bias_reg, anti_droop_bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            surface_rate_reg    <= adrl_pkg::SURFACE_RATE_RST;
            droop_rate_reg      <= adrl_pkg::DROOP_RATE_RST;
            anti_droop_rate_reg <= adrl_pkg::ANTI_DROOP_RATE_RST;
            pitch_ref_reg       <= adrl_pkg::PITCH_REF_RST;
            flaps_thresh_reg    <= adrl_pkg::FLAPS_THRESH_RST;
            droop_delay_reg     <= adrl_pkg::DROOP_DELAY_RST;
            droop_bias_reg      <= adrl_pkg::DROOP_BIAS_RST;
            anti_droop_bias_reg <= adrl_pkg::ANTI_DROOP_BIAS_RST;
        end else if (cfg_we) begin
            unique case (adrl_pkg::cfg_reg_t'(cfg_addr))
                adrl_pkg::REG_SURFACE_RATE:    surface_rate_reg    <= cfg_wdata;
                adrl_pkg::REG_DROOP_RATE:      droop_rate_reg      <= cfg_wdata;
                adrl_pkg::REG_ANTI_DROOP_RATE: anti_droop_rate_reg <= cfg_wdata;
                adrl_pkg::REG_PITCH_REFERENCE: pitch_ref_reg       <= $signed(cfg_wdata[14:0]);
                adrl_pkg::REG_FLAPS_THRESHOLD: flaps_thresh_reg    <= cfg_wdata[14:0];
                adrl_pkg::REG_DROOP_DELAY_MS:  droop_delay_reg     <= cfg_wdata;
                adrl_pkg::REG_DROOP_BIAS:      droop_bias_reg      <= $signed(cfg_wdata);
                adrl_pkg::REG_ANTI_DROOP_BIAS: anti_droop_bias_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                              in_valid_reg;
    logic [adrl_pkg::IN_USED_W-1:0]    in_data_reg;
    logic                              out_valid_reg;
    logic                              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[adrl_pkg::IN_USED_W-1:0];
        end
    end

    // field decode
    logic                                    ap, spl;
    logic [adrl_pkg::NOW_W-1:0]              now_ms;
    logic signed [adrl_pkg::PITCH_W-1:0]     pitch;
    logic [adrl_pkg::HANDLE_W-1:0]           handle;
    logic [adrl_pkg::FLAPS_W-1:0]            flaps;
    logic signed [adrl_pkg::CMD_W-1:0]       cmd;
    logic [adrl_pkg::MS_W-1:0]               frame_ms;

    assign ap       = in_data_reg[adrl_pkg::AP_LSB];
    assign spl      = in_data_reg[adrl_pkg::SPL_LSB];
    assign now_ms   = in_data_reg[adrl_pkg::NOW_LSB +: adrl_pkg::NOW_W];
    assign pitch    = $signed(in_data_reg[adrl_pkg::PITCH_LSB +: adrl_pkg::PITCH_W]);
    assign handle   = in_data_reg[adrl_pkg::HANDLE_LSB +: adrl_pkg::HANDLE_W];
    assign flaps    = in_data_reg[adrl_pkg::FLAPS_LSB +: adrl_pkg::FLAPS_W];
    assign cmd      = $signed(in_data_reg[adrl_pkg::CMD_LSB +: adrl_pkg::CMD_W]);
    assign frame_ms = in_data_reg[adrl_pkg::MS_LSB +: adrl_pkg::MS_W];

    // ------------------------------------------------------------------
    // limiter state (the position registers also serve as the result)
    // ------------------------------------------------------------------
    logic                  spoilers_before_reg, spoilers_before_next;
    logic                  blocked_reg, blocked_next;
    logic [14:0]           flaps_before_reg, flaps_before_next;
    logic [31:0]           crossing_time_reg, crossing_time_next;
    logic signed [15:0]    droop_goal_reg, droop_goal_next;
    logic signed [15:0]    droop_now_reg, droop_now_next;
    logic signed [15:0]    anti_droop_now_reg, anti_droop_now_next;
    logic signed [P-1:0]   left_reg, left_next;
    logic signed [P-1:0]   right_reg, right_next;

    // move cur toward goal by at most step
    function automatic logic signed [SL_W-1:0] slew(
        input logic signed [SL_W-1:0] cur,
        input logic signed [SL_W-1:0] goal,
        input logic [STEP_W-1:0]      step
    );
        logic signed [DW-1:0] c, g, s, d;
        c = DW'(cur);
        g = DW'(goal);
        s = $signed(DW'(step));
        if (g > c) begin
            d = g - c;
            slew = (d > s) ? SL_W'(c + s) : goal;
        end else begin
            d = c - g;
            slew = (d > s) ? SL_W'(c - s) : goal;
        end
    endfunction

    function automatic logic signed [P-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [EXT_W-1:0] x;
        x = EXT_W'(v);
        if (x > POS_HI) begin
            sat_pos = P'(POS_HI);
        end else if (x < POS_LO) begin
            sat_pos = P'(POS_LO);
        end else begin
            sat_pos = P'(x);
        end
    endfunction

    logic [STEP_W-1:0]       surface_step, droop_step, anti_step;
    logic signed [15:0]      ad_goal;
    logic signed [15:0]      neg_pitch;
    logic signed [15:0]      pitch_ref_ext;
    logic                    was_above, is_above;
    logic [31:0]             elapsed;
    logic signed [16:0]      bias;
    logic signed [SUM_W-1:0] left_goal_raw, right_goal_raw;

    assign surface_step = surface_rate_reg * frame_ms;
    assign droop_step   = droop_rate_reg * frame_ms;
    assign anti_step    = anti_droop_rate_reg * frame_ms;

    always_comb begin
        // set the inhibit when spoilers deploy under autopilot, drop it on retract
        if (!spoilers_before_reg && spl && ap) begin
            blocked_next = 1'b1;
        end else if (!spl) begin
            blocked_next = 1'b0;
        end else begin
            blocked_next = blocked_reg;
        end
        spoilers_before_next = spl;

        neg_pitch     = -16'(pitch);
        pitch_ref_ext = 16'(pitch_ref_reg);
        ad_goal = (spl && !blocked_next && (neg_pitch < pitch_ref_ext) && (handle != '0))
                  ? anti_droop_bias_reg : 16'sd0;
        anti_droop_now_next = 16'(slew(SL_W'(anti_droop_now_reg), SL_W'(ad_goal), anti_step));

        was_above = flaps_before_reg > flaps_thresh_reg;
        is_above  = flaps > flaps_thresh_reg;
        crossing_time_next = (was_above != is_above) ? now_ms : crossing_time_reg;
        elapsed = now_ms - crossing_time_next;
        if (elapsed >= 32'(droop_delay_reg)) begin
            droop_goal_next = is_above ? droop_bias_reg : 16'sd0;
        end else begin
            droop_goal_next = droop_goal_reg;
        end
        droop_now_next = 16'(slew(SL_W'(droop_now_reg), SL_W'(droop_goal_next), droop_step));
        flaps_before_next = flaps;

        bias           = 17'(droop_now_next) + 17'(anti_droop_now_next);
        left_goal_raw  = SUM_W'(cmd) + SUM_W'(bias);
        right_goal_raw = SUM_W'(cmd) - SUM_W'(bias);
        left_next  = P'(slew(SL_W'(left_reg), SL_W'(sat_pos(left_goal_raw)), surface_step));
        right_next = P'(slew(SL_W'(right_reg), SL_W'(sat_pos(right_goal_raw)), surface_step));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg       <= 1'b0;
            spoilers_before_reg <= 1'b0;
            blocked_reg         <= 1'b0;
            flaps_before_reg    <= '0;
            crossing_time_reg   <= '0;
            droop_goal_reg      <= '0;
            droop_now_reg       <= '0;
            anti_droop_now_reg  <= '0;
            left_reg            <= '0;
            right_reg           <= '0;
        end else begin
            if (advance) begin
                out_valid_reg       <= 1'b1;
                spoilers_before_reg <= spoilers_before_next;
                blocked_reg         <= blocked_next;
                flaps_before_reg    <= flaps_before_next;
                crossing_time_reg   <= crossing_time_next;
                droop_goal_reg      <= droop_goal_next;
                droop_now_reg       <= droop_now_next;
                anti_droop_now_reg  <= anti_droop_now_next;
                left_reg            <= left_next;
                right_reg           <= right_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result
    // ------------------------------------------------------------------
    logic [adrl_pkg::OUT_FIELD_W-1:0] left_out, right_out;

    generate
        if (P >= adrl_pkg::OUT_FIELD_W) begin : g_trunc
            assign left_out  = left_reg[adrl_pkg::OUT_FIELD_W-1:0];
            assign right_out = right_reg[adrl_pkg::OUT_FIELD_W-1:0];
        end else begin : g_sext
            assign left_out  = {{(adrl_pkg::OUT_FIELD_W - P){left_reg[P-1]}}, left_reg};
            assign right_out = {{(adrl_pkg::OUT_FIELD_W - P){right_reg[P-1]}}, right_reg};
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {right_out, left_out};

endmodule : aileron_droop_rate_limiter_unit
`default_nettype wire

// ===== rtl/adrl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adrl_checker
// Port-level checks for the aileron droop rate limiter.
// ----------------------------------------------------------------------------
module adrl_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [adrl_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a draining output always frees the input side
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // no result without a request seen by s_fire or by $past(s_fire)
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !s_fire && !$past(s_fire) |=> !m_tvalid)
        else $error("result without request");

endmodule : adrl_checker

bind aileron_droop_rate_limiter_unit adrl_checker u_adrl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
